@@ rtl/bts_pkg.sv @@
// shared constants, codes and types of the bilinear texture sampler
// no dependencies; imported by every other file of the block
package bts_pkg;

    // defaults of the top-level parameters
    localparam int MAX_SIDE_DEF    = 256;
    localparam int TEXEL_COUNT_DEF = 65536;
    localparam int COORD_FRAC_DEF  = 16;

    // fixed field widths
    localparam int COORD_W      = 20;
    localparam int TEXEL_ADDR_W = 16;
    localparam int CHAN_W       = 8;
    localparam int NUM_CHAN     = 4;
    localparam int TEXEL_W      = NUM_CHAN * CHAN_W;
    localparam int OUT_W        = 16;

    // configuration port
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_RESET_SIDE = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = CFG_IDX_W'(1);

    // operation codes of an input word
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // channel positions in a texel and in a result word
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    // texel corners: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
    localparam int NUM_CORNER = 4;

    // result queue depth, covers the sample pipeline plus one
    localparam int OUT_DEPTH = 8;

    // texel memory access issued by the address stage
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

endpackage

@@ rtl/bts_if.sv @@
// channel interfaces of the bilinear texture sampler
// depends on bts_pkg for field widths
interface bts_tex_if
    import bts_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [TEXEL_ADDR_W-1:0]   texel_addr;
    logic [CHAN_W-1:0]         in_red;
    logic [CHAN_W-1:0]         in_green;
    logic [CHAN_W-1:0]         in_blue;
    logic [CHAN_W-1:0]         in_alpha;
    logic signed [COORD_W-1:0] coord_u;
    logic signed [COORD_W-1:0] coord_v;

    modport source (
        output valid, operation, texel_addr, in_red, in_green, in_blue, in_alpha,
               coord_u, coord_v,
        input  ready
    );
    modport sink (
        input  valid, operation, texel_addr, in_red, in_green, in_blue, in_alpha,
               coord_u, coord_v,
        output ready
    );
endinterface

interface bts_smp_if
    import bts_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] out_red;
    logic [OUT_W-1:0] out_green;
    logic [OUT_W-1:0] out_blue;
    logic [OUT_W-1:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

interface bts_cfg_if
    import bts_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (
        output valid, reg_index, wr_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, wr_data,
        output ready
    );
endinterface

@@ rtl/bts_ram.sv @@
// generic single-clock ram, one write port and one read port, registered read
// depends on bts_pkg for default sizes
module bts_ram
    import bts_pkg::*;
#(
    parameter int WIDTH = TEXEL_W,
    parameter int DEPTH = TEXEL_COUNT_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bts_addr.sv @@
// coordinate clamp, scaling and texel address generation, three stages
// depends on bts_pkg; feeds the texel memories of the top level
module bts_addr
    import bts_pkg::*;
#(
    parameter int MAX_SIDE        = MAX_SIDE_DEF,
    parameter int TEXEL_COUNT     = TEXEL_COUNT_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    localparam int XW     = $clog2(MAX_SIDE),
    localparam int SIDE_W = $clog2(MAX_SIDE + 1),
    localparam int ADDR_W = $clog2(TEXEL_COUNT),
    localparam int F      = COORD_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic                               i_operation,
    input  logic [TEXEL_ADDR_W-1:0]            i_texel_addr,
    input  logic [TEXEL_W-1:0]                 i_wdata,
    input  logic signed [COORD_W-1:0]          i_coord_u,
    input  logic signed [COORD_W-1:0]          i_coord_v,
    input  logic [SIDE_W-1:0]                  i_side_w,
    input  logic [XW-1:0]                      i_w_m1,
    input  logic [XW-1:0]                      i_h_m1,
    output t_mem_ctl                           o_mem,
    output logic [NUM_CORNER-1:0][ADDR_W-1:0]  o_addr,
    output logic [TEXEL_W-1:0]                 o_wdata,
    output logic [F-1:0]                       o_fx,
    output logic [F-1:0]                       o_fy
);

    localparam int CL_W  = F + 1;
    localparam int P_W   = F + XW;
    localparam int CMP_W = (COORD_W - 1 > CL_W) ? COORD_W - 1 : CL_W;
    localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(2 ** F);
    localparam int ROW_W = XW + SIDE_W;
    localparam int SUM_W = ROW_W + 1;

    function automatic logic [CL_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] c);
        logic [CMP_W-1:0] mag;
        mag = CMP_W'(c[COORD_W-2:0]);
        if (c[COORD_W-1]) return '0;
        if (mag > ONE_CMP) return CL_W'(ONE_CMP);
        return CL_W'(mag);
    endfunction

    // stage 1: clamp and scale by side minus one
    logic [CL_W-1:0]    clamp_u, clamp_v;
    logic [CL_W+XW-1:0] prod_u, prod_v;

    logic               r1_valid;
    logic               r1_op;
    logic [ADDR_W-1:0]  r1_waddr;
    logic [TEXEL_W-1:0] r1_wdata;
    logic [P_W-1:0]     r1_pu, r1_pv;

    assign clamp_u = clamp_coord(i_coord_u);
    assign clamp_v = clamp_coord(i_coord_v);
    assign prod_u  = clamp_u * i_w_m1;
    assign prod_v  = clamp_v * i_h_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r1_op    <= i_operation;
            r1_waddr <= ADDR_W'(i_texel_addr);
            r1_wdata <= i_wdata;
            r1_pu    <= prod_u[P_W-1:0];
            r1_pv    <= prod_v[P_W-1:0];
        end
    end

    // stage 2: integer parts, clamped neighbours, row offsets
    logic [XW-1:0]    x0, y0, x1, y1;
    logic [ROW_W-1:0] row0, row1;

    logic               r2_valid;
    logic               r2_op;
    logic [ADDR_W-1:0]  r2_waddr;
    logic [TEXEL_W-1:0] r2_wdata;
    logic [XW-1:0]      r2_x0, r2_x1;
    logic [ROW_W-1:0]   r2_row0, r2_row1;
    logic [F-1:0]       r2_fx, r2_fy;

    assign x0   = r1_pu[P_W-1:F];
    assign y0   = r1_pv[P_W-1:F];
    assign x1   = (x0 == i_w_m1) ? x0 : x0 + XW'(1);
    assign y1   = (y0 == i_h_m1) ? y0 : y0 + XW'(1);
    assign row0 = y0 * i_side_w;
    assign row1 = y1 * i_side_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid) begin
            r2_op    <= r1_op;
            r2_waddr <= r1_waddr;
            r2_wdata <= r1_wdata;
            r2_x0    <= x0;
            r2_x1    <= x1;
            r2_row0  <= row0;
            r2_row1  <= row1;
            r2_fx    <= r1_pu[F-1:0];
            r2_fy    <= r1_pv[F-1:0];
        end
    end

    // stage 3: linear addresses, wrapped to the store size
    logic [NUM_CORNER-1:0][ADDR_W-1:0] n_addr;

    logic                              r3_valid;
    logic                              r3_op;
    logic [NUM_CORNER-1:0][ADDR_W-1:0] r3_addr;
    logic [TEXEL_W-1:0]                r3_wdata;
    logic [F-1:0]                      r3_fx, r3_fy;

    always_comb begin
        n_addr[0] = ADDR_W'(SUM_W'(r2_x0) + SUM_W'(r2_row0));
        n_addr[1] = ADDR_W'(SUM_W'(r2_x1) + SUM_W'(r2_row0));
        n_addr[2] = ADDR_W'(SUM_W'(r2_x0) + SUM_W'(r2_row1));
        n_addr[3] = ADDR_W'(SUM_W'(r2_x1) + SUM_W'(r2_row1));
        // a write uses corner 0's slot for its own address
        if (r2_op == OP_WRITE) begin
            n_addr[0] = r2_waddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_valid) begin
            r3_op    <= r2_op;
            r3_addr  <= n_addr;
            r3_wdata <= r2_wdata;
            r3_fx    <= r2_fx;
            r3_fy    <= r2_fy;
        end
    end

    assign o_mem.wr = r3_valid && (r3_op == OP_WRITE);
    assign o_mem.rd = r3_valid && (r3_op == OP_SAMPLE);
    assign o_addr   = r3_addr;
    assign o_wdata  = r3_wdata;
    assign o_fx     = r3_fx;
    assign o_fy     = r3_fy;

endmodule

@@ rtl/bts_filter.sv @@
// per-channel lerp along v then along u, rounded to 8.8, three stages
// depends on bts_pkg; takes texel data straight from the memories
module bts_filter
    import bts_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    localparam int F = COORD_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_mem_ctl                           i_mem,
    input  logic [F-1:0]                       i_fx,
    input  logic [F-1:0]                       i_fy,
    input  logic [NUM_CORNER-1:0][TEXEL_W-1:0] i_texel,
    output logic                               o_push,
    output logic [NUM_CHAN-1:0][OUT_W-1:0]     o_word
);

    localparam int CL_W   = F + 1;
    localparam int LEFT_W = CHAN_W + F;
    localparam int FULL_W = 2 * F + CHAN_W;
    localparam int SH     = 2 * F - CHAN_W;
    localparam logic [CL_W-1:0]   ONE  = {1'b1, {F{1'b0}}};
    localparam logic [FULL_W-1:0] HALF = {{(FULL_W-1){1'b0}}, 1'b1} << (SH - 1);

    // stage 4: fractions line up with the memory read data
    logic         r4_valid;
    logic [F-1:0] r4_fx, r4_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= i_mem.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem.rd) begin
            r4_fx <= i_fx;
            r4_fy <= i_fy;
        end
    end

    logic [CL_W-1:0] fy_pos, fy_neg, fx_pos, fx_neg;
    assign fy_pos = CL_W'(r4_fy);
    assign fy_neg = ONE - fy_pos;

    logic                          r5_valid;
    logic [NUM_CHAN-1:0][LEFT_W-1:0] r5_left, r5_right;
    logic [F-1:0]                  r5_fx;

    logic                          r6_valid;
    logic [NUM_CHAN-1:0][FULL_W-1:0] r6_full;

    assign fx_pos = CL_W'(r5_fx);
    assign fx_neg = ONE - fx_pos;

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        logic [CHAN_W-1:0]      t00, t10, t01, t11;
        logic [LEFT_W:0]        left_sum, right_sum;
        logic [FULL_W:0]        full_sum;
        logic [FULL_W-1:0]      rounded;

        assign t00 = i_texel[0][c*CHAN_W +: CHAN_W];
        assign t10 = i_texel[1][c*CHAN_W +: CHAN_W];
        assign t01 = i_texel[2][c*CHAN_W +: CHAN_W];
        assign t11 = i_texel[3][c*CHAN_W +: CHAN_W];

        // lerp along v for the left and right columns
        assign left_sum  = t00 * fy_neg + t01 * fy_pos;
        assign right_sum = t10 * fy_neg + t11 * fy_pos;

        // lerp along u
        assign full_sum = r5_left[c] * fx_neg + r5_right[c] * fx_pos;

        // round half up; never carries out of the full width
        assign rounded   = r6_full[c] + HALF;
        assign o_word[c] = rounded[FULL_W-1:SH];

        always_ff @(posedge i_clk) begin
            if (r4_valid) begin
                r5_left[c]  <= left_sum[LEFT_W-1:0];
                r5_right[c] <= right_sum[LEFT_W-1:0];
            end
            if (r5_valid) begin
                r6_full[c] <= full_sum[FULL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r4_valid) begin
            r5_fx <= r4_fx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    assign o_push = r6_valid;

endmodule

@@ rtl/bts_outq.sv @@
// result queue between the filter pipeline and the output channel
// depends on bts_pkg for default sizes
module bts_outq
    import bts_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH,
    parameter int WIDTH = NUM_CHAN * OUT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rptr];

endmodule

@@ rtl/bilinear_texture_sampler.sv @@
// bilinear rgba8 texture sampler, top level
// depends on bts_pkg, bts_if, bts_ram, bts_addr, bts_filter, bts_outq
//
// One word is taken on every clock the input is ready: a write word stores one
// texel at its linear address, a sample word returns one filtered rgba result in
// 8.8 fixed point after three address stages, one memory read, two lerp stages
// and one queue stage, and a write never returns anything. The rate of one word
// a clock is set by the texel store: it is held as four identical copies of
// TEXEL_COUNT entries each, every write goes to all four, and each sample reads
// its four corner texels one from each copy in the same cycle. Writes and reads
// meet the store in the same pipeline stage and in word order, so a sample sees
// every write taken before it. TEXEL_COUNT is a power of two and addresses wrap
// at it. The store starts undefined and needs no clearing pass; samples of
// texels never written return unspecified data. An eight-entry result queue
// decouples the output side, and the input stays ready as long as fewer than
// eight samples are waiting or in flight. Width and height are to be written
// through the configuration channel only while idle, not enforced by the block.
module bilinear_texture_sampler
    import bts_pkg::*;
#(
    parameter int MAX_SIDE        = MAX_SIDE_DEF,
    parameter int TEXEL_COUNT     = TEXEL_COUNT_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bts_tex_if.sink   i_tex,
    bts_smp_if.source o_smp,
    bts_cfg_if.sink   i_cfg
);

    localparam int XW         = $clog2(MAX_SIDE);
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int SCMP_W     = (CFG_DATA_W > SIDE_W) ? CFG_DATA_W : SIDE_W;
    localparam int ADDR_W     = $clog2(TEXEL_COUNT);
    localparam int CNT_W      = $clog2(OUT_DEPTH + 1);
    localparam int RESET_SIDE = (CFG_RESET_SIDE > MAX_SIDE) ? MAX_SIDE : CFG_RESET_SIDE;

    // a zero side acts as one, anything beyond the maximum as the maximum
    function automatic logic [SIDE_W-1:0] side_eff(input logic [CFG_DATA_W-1:0] v);
        logic [SCMP_W-1:0] ext;
        ext = SCMP_W'(v);
        if (ext == '0) return SIDE_W'(1);
        if (ext > SCMP_W'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
        return SIDE_W'(ext);
    endfunction

    // ---------------------------------------------------------------
    // configuration: keep the effective width and both sides minus one
    // ---------------------------------------------------------------
    logic              cfg_acc;
    logic [SIDE_W-1:0] cfg_side;
    logic [XW-1:0]     cfg_m1;

    logic [SIDE_W-1:0] r_side_w;
    logic [XW-1:0]     r_w_m1;
    logic [XW-1:0]     r_h_m1;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid & i_cfg.ready;
    assign cfg_side    = side_eff(i_cfg.wr_data);
    assign cfg_m1      = XW'(cfg_side - SIDE_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_w <= SIDE_W'(RESET_SIDE);
            r_w_m1   <= XW'(RESET_SIDE - 1);
            r_h_m1   <= XW'(RESET_SIDE - 1);
        end else if (cfg_acc) begin
            unique case (i_cfg.reg_index)
                CFG_TEX_WIDTH: begin
                    r_side_w <= cfg_side;
                    r_w_m1   <= cfg_m1;
                end
                CFG_TEX_HEIGHT: begin
                    r_h_m1 <= cfg_m1;
                end
                default: begin
                    // unknown register index, ignored
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input side: ready while the result queue has room for every
    // sample not yet delivered, so the pipeline itself never stalls
    // ---------------------------------------------------------------
    logic             tex_acc;
    logic             smp_acc;
    logic             out_acc;
    logic [CNT_W-1:0] r_pending, n_pending;

    assign i_tex.ready = (r_pending < CNT_W'(OUT_DEPTH));
    assign tex_acc     = i_tex.valid & i_tex.ready;
    assign smp_acc     = tex_acc & (i_tex.operation == OP_SAMPLE);
    assign out_acc     = o_smp.valid & o_smp.ready;
    assign n_pending   = r_pending + CNT_W'(smp_acc) - CNT_W'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // texel word as stored: red in the low byte, alpha in the high byte
    logic [TEXEL_W-1:0] tex_wdata;
    assign tex_wdata = {i_tex.in_alpha, i_tex.in_blue, i_tex.in_green, i_tex.in_red};

    // ---------------------------------------------------------------
    // address generation
    // ---------------------------------------------------------------
    t_mem_ctl                          mem;
    logic [NUM_CORNER-1:0][ADDR_W-1:0] mem_addr;
    logic [TEXEL_W-1:0]                mem_wdata;
    logic [COORD_FRAC_BITS-1:0]        frac_x, frac_y;

    bts_addr #(
        .MAX_SIDE        (MAX_SIDE),
        .TEXEL_COUNT     (TEXEL_COUNT),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_addr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (tex_acc),
        .i_operation  (i_tex.operation),
        .i_texel_addr (i_tex.texel_addr),
        .i_wdata      (tex_wdata),
        .i_coord_u    (i_tex.coord_u),
        .i_coord_v    (i_tex.coord_v),
        .i_side_w     (r_side_w),
        .i_w_m1       (r_w_m1),
        .i_h_m1       (r_h_m1),
        .o_mem        (mem),
        .o_addr       (mem_addr),
        .o_wdata      (mem_wdata),
        .o_fx         (frac_x),
        .o_fy         (frac_y)
    );

    // ---------------------------------------------------------------
    // texel store: four copies, written together, one corner read each
    // ---------------------------------------------------------------
    logic [NUM_CORNER-1:0][TEXEL_W-1:0] corner_texel;

    for (genvar k = 0; k < NUM_CORNER; k++) begin : g_store
        bts_ram #(
            .WIDTH (TEXEL_W),
            .DEPTH (TEXEL_COUNT)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (mem.wr),
            .i_waddr (mem_addr[0]),
            .i_wdata (mem_wdata),
            .i_re    (mem.rd),
            .i_raddr (mem_addr[k]),
            .o_rdata (corner_texel[k])
        );
    end

    // ---------------------------------------------------------------
    // filter and result queue
    // ---------------------------------------------------------------
    logic                           res_push;
    logic [NUM_CHAN-1:0][OUT_W-1:0] res_word;
    logic [NUM_CHAN-1:0][OUT_W-1:0] q_word;

    bts_filter #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mem   (mem),
        .i_fx    (frac_x),
        .i_fy    (frac_y),
        .i_texel (corner_texel),
        .o_push  (res_push),
        .o_word  (res_word)
    );

    bts_outq #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (NUM_CHAN * OUT_W)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_word),
        .i_pop   (out_acc),
        .o_valid (o_smp.valid),
        .o_data  (q_word)
    );

    assign o_smp.out_red   = q_word[CH_RED];
    assign o_smp.out_green = q_word[CH_GREEN];
    assign o_smp.out_blue  = q_word[CH_BLUE];
    assign o_smp.out_alpha = q_word[CH_ALPHA];

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench of bilinear_texture_sampler: random and directed texel writes,
// samples and size settings; a scoreboard class predicts the filtered colours in order
// depends on bts_pkg, the bts_*_if interfaces and the rtl of the block
module tb_top;
    import bts_pkg::*;

    localparam int COORD_ONE      = 1 << COORD_FRAC_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 12;   // sample pipeline is seven deep
    localparam int LONG_HOLD      = 80;   // receiver hold-off, well past the queue depth
    localparam int NUM_PHASES     = 10;
    localparam int HOLD_PHASE     = 2;
    localparam int PHASE_WORDS    = 84;
    localparam int MAX_REPORTS    = 40;

    // one input word as the sender sees it
    typedef struct packed {
        logic                      op;
        logic [TEXEL_ADDR_W-1:0]   addr;
        logic [CHAN_W-1:0]         red;
        logic [CHAN_W-1:0]         green;
        logic [CHAN_W-1:0]         blue;
        logic [CHAN_W-1:0]         alpha;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
    } t_tex_word;

    // filtered colour, indexed by CH_RED .. CH_ALPHA
    typedef logic [NUM_CHAN-1:0][OUT_W-1:0] t_rgba;

    // texel store shadow, size registers and the queue of filtered colours still owed
    class texel_scoreboard;
        logic [TEXEL_W-1:0]    texels  [TEXEL_COUNT_DEF];
        bit                    written [TEXEL_COUNT_DEF];
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        t_rgba                 filtered_q [$];
        int                    mismatches;
        int                    checked;

        function new();
            width_reg  = CFG_RESET_SIDE;
            height_reg = CFG_RESET_SIDE;
        endfunction

        task report(input string what);
            if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        function int pending();
            return filtered_q.size();
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TEX_WIDTH) width_reg = data;
            else if (idx == CFG_TEX_HEIGHT) height_reg = data;
        endfunction

        // zero acts as one, anything past the largest side as the largest side
        function longint unsigned side(input logic [CFG_DATA_W-1:0] r);
            if (r == 0) return 1;
            if (r > MAX_SIDE_DEF) return MAX_SIDE_DEF;
            return r;
        endfunction

        function longint unsigned clamp_coord(input logic signed [COORD_W-1:0] c);
            longint s;
            s = c;
            if (s < 0) return 0;
            if (s > COORD_ONE) return COORD_ONE;
            return s;
        endfunction

        // corner addresses (x0,y0) (x1,y0) (x0,y1) (x1,y1) and the two weights
        function void locate(input logic signed [COORD_W-1:0] u,
                             input logic signed [COORD_W-1:0] v,
                             output logic [NUM_CORNER-1:0][TEXEL_ADDR_W-1:0] corner,
                             output longint unsigned fx,
                             output longint unsigned fy);
            longint unsigned w, h, pu, pv, x0, y0, x1, y1;
            w  = side(width_reg);
            h  = side(height_reg);
            pu = clamp_coord(u) * (w - 1);
            pv = clamp_coord(v) * (h - 1);
            x0 = pu >> COORD_FRAC_DEF;
            y0 = pv >> COORD_FRAC_DEF;
            fx = pu & (COORD_ONE - 1);
            fy = pv & (COORD_ONE - 1);
            x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
            y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
            corner[0] = TEXEL_ADDR_W'(x0 + y0 * w);
            corner[1] = TEXEL_ADDR_W'(x1 + y0 * w);
            corner[2] = TEXEL_ADDR_W'(x0 + y1 * w);
            corner[3] = TEXEL_ADDR_W'(x1 + y1 * w);
        endfunction

        // lerp along v, then along u, round half up once to 8.8
        function t_rgba filter_sample(input logic signed [COORD_W-1:0] u,
                                      input logic signed [COORD_W-1:0] v);
            logic [NUM_CORNER-1:0][TEXEL_ADDR_W-1:0] corner;
            logic [NUM_CORNER-1:0][TEXEL_W-1:0]      t;
            longint unsigned fx, fy, one, left, right, full;
            longint unsigned c00, c10, c01, c11;
            t_rgba colour;
            one = COORD_ONE;
            locate(u, v, corner, fx, fy);
            for (int k = 0; k < NUM_CORNER; k++) t[k] = texels[corner[k]];
            for (int c = 0; c < NUM_CHAN; c++) begin
                c00   = t[0][CHAN_W*c +: CHAN_W];
                c10   = t[1][CHAN_W*c +: CHAN_W];
                c01   = t[2][CHAN_W*c +: CHAN_W];
                c11   = t[3][CHAN_W*c +: CHAN_W];
                left  = c00 * (one - fy) + c01 * fy;
                right = c10 * (one - fy) + c11 * fy;
                full  = left * (one - fx) + right * fx;
                colour[c] = OUT_W'((full + (64'd1 << (2*COORD_FRAC_DEF - 9)))
                                   >> (2*COORD_FRAC_DEF - 8));
            end
            return colour;
        endfunction

        function void note_word(input t_tex_word w);
            if (w.op == OP_WRITE) begin
                texels[w.addr]  = {w.alpha, w.blue, w.green, w.red};
                written[w.addr] = 1'b1;
            end else begin
                filtered_q.push_back(filter_sample(w.u, w.v));
            end
        endfunction

        task check_colour(input t_rgba got);
            string names [NUM_CHAN];
            t_rgba want;
            names = '{"red", "green", "blue", "alpha"};
            if (filtered_q.size() == 0) begin
                report($sformatf("result %h with no sample owed", got));
                return;
            end
            want = filtered_q.pop_front();
            checked++;
            for (int c = 0; c < NUM_CHAN; c++)
                if (got[c] !== want[c])
                    report($sformatf("%s got %h want %h", names[c], got[c], want[c]));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    bts_tex_if tex ();
    bts_smp_if smp ();
    bts_cfg_if cfg ();

    bilinear_texture_sampler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tex   (tex),
        .o_smp   (smp),
        .i_cfg   (cfg)
    );

    texel_scoreboard sb;
    bit              bursts_on = 1'b1;   // random idling on both sides
    bit              hold_req  = 1'b0;   // asks the receiver for one long hold-off
    int              words_sent;
    int              size_settings;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offers one word and waits for its handshake; valid is left high so that a
    // following word goes out back to back
    task automatic send_word(input t_tex_word w);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            tex.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        tex.operation  <= w.op;
        tex.texel_addr <= w.addr;
        tex.in_red     <= w.red;
        tex.in_green   <= w.green;
        tex.in_blue    <= w.blue;
        tex.in_alpha   <= w.alpha;
        tex.coord_u    <= w.u;
        tex.coord_v    <= w.v;
        tex.valid      <= 1'b1;
        do @(posedge i_clk); while (tex.ready !== 1'b1);
        sb.note_word(w);
        words_sent++;
    endtask

    // opaque sources give alpha 255, so weight that value up
    function automatic logic [TEXEL_W-1:0] random_texel();
        logic [TEXEL_W-1:0] d;
        d = $urandom;
        if ($urandom_range(0, 3) == 0) d[CHAN_W*CH_ALPHA +: CHAN_W] = 8'hff;
        return d;
    endfunction

    task automatic put_texel(input logic [TEXEL_ADDR_W-1:0] addr,
                             input logic [TEXEL_W-1:0] data);
        t_tex_word w;
        w.op   = OP_WRITE;
        w.addr = addr;
        {w.alpha, w.blue, w.green, w.red} = data;
        w.u    = COORD_W'($urandom);   // ignored by a write
        w.v    = COORD_W'($urandom);
        send_word(w);
    endtask

    // any corner not yet written gets a texel first, so no read sees an empty entry
    task automatic sample_at(input logic signed [COORD_W-1:0] u,
                             input logic signed [COORD_W-1:0] v);
        logic [NUM_CORNER-1:0][TEXEL_ADDR_W-1:0] corner;
        longint unsigned fx, fy;
        t_tex_word w;
        sb.locate(u, v, corner, fx, fy);
        for (int k = 0; k < NUM_CORNER; k++)
            if (!sb.written[corner[k]]) put_texel(corner[k], random_texel());
        w.op   = OP_SAMPLE;
        w.addr = TEXEL_ADDR_W'($urandom);
        {w.alpha, w.blue, w.green, w.red} = $urandom;
        w.u    = u;
        w.v    = v;
        send_word(w);
    endtask

    // mostly inside 0..1, with exact ends, overshoot and raw values that are often negative
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return COORD_W'(COORD_ONE);
            2:       return COORD_W'(COORD_ONE + $urandom_range(1, 20'h7ffff - COORD_ONE));
            3, 4:    return COORD_W'($urandom);
            default: return COORD_W'($urandom_range(0, COORD_ONE));
        endcase
    endfunction

    task automatic random_word();
        int unsigned w, h;
        w = int'(sb.side(sb.width_reg));
        h = int'(sb.side(sb.height_reg));
        if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 2) != 0)
                put_texel(TEXEL_ADDR_W'($urandom_range(0, w - 1) + $urandom_range(0, h - 1) * w),
                          random_texel());
            else
                put_texel(TEXEL_ADDR_W'($urandom), random_texel());
        end else begin
            sample_at(pick_coord(), pick_coord());
        end
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg.reg_index <= idx;
        cfg.wr_data   <= data;
        cfg.valid     <= 1'b1;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    // sender stops, every owed colour comes back, trailing writes drain, then the sizes
    // change; an unused register index goes in between and must be ignored
    task automatic program_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        tex.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_put(CFG_TEX_WIDTH, w);
        cfg_put(CFG_IDX_W'($urandom_range(CFG_TEX_HEIGHT + 1, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
        cfg_put(CFG_TEX_HEIGHT, h);
        cfg.valid <= 1'b0;
        size_settings++;
    endtask

    // receiver: checks every colour taken, stalls in bursts, and once holds off long
    // enough for the result queue to fill and the input to back up
    initial begin
        int    stall;
        t_rgba got;
        stall = 0;
        smp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (smp.valid === 1'b1 && smp.ready === 1'b1) begin
                got[CH_RED]   = smp.out_red;
                got[CH_GREEN] = smp.out_green;
                got[CH_BLUE]  = smp.out_blue;
                got[CH_ALPHA] = smp.out_alpha;
                sb.check_colour(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
            end else if (stall == 0 && bursts_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 15);
            end
            if (stall > 0) begin
                smp.ready <= 1'b0;
                stall--;
            end else begin
                smp.ready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any handshake on any channel ends the run
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((tex.valid === 1'b1 && tex.ready === 1'b1) ||
                (smp.valid === 1'b1 && smp.ready === 1'b1) ||
                (cfg.valid === 1'b1 && cfg.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("bilinear_texture_sampler test failed");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] phase_w [0:NUM_PHASES-1];
        logic [CFG_DATA_W-1:0] phase_h [0:NUM_PHASES-1];
        int                    phase_start;
        sb = new();
        // zero and codes above the largest side stand in for one and the largest side
        phase_w = '{9'd1, 9'd2, 9'd17, 9'd0,   9'd3, 9'd511, 9'd256, 9'd7,   9'd64, 9'd4};
        phase_h = '{9'd1, 9'd2, 9'd9,  9'd511, 9'd5, 9'd0,   9'd256, 9'd300, 9'd4,  9'd3};

        i_rst_n        <= 1'b0;
        tex.valid      <= 1'b0;
        tex.operation  <= OP_WRITE;
        tex.texel_addr <= '0;
        tex.in_red     <= '0;
        tex.in_green   <= '0;
        tex.in_blue    <= '0;
        tex.in_alpha   <= '0;
        tex.coord_u    <= '0;
        tex.coord_v    <= '0;
        cfg.valid      <= 1'b0;
        cfg.reg_index  <= CFG_TEX_WIDTH;
        cfg.wr_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset sizes of 256 by 256, extreme bytes around the origin and far corner
        put_texel(16'd0,     32'hffffffff);
        put_texel(16'd1,     32'h00000000);
        put_texel(16'd256,   32'hff00ff00);
        put_texel(16'd257,   32'h01807ffe);
        put_texel(16'hffff,  32'hff0ff055);
        sample_at('0, '0);                     // exact corner, no weights
        sample_at(20'sh00080, 20'sh00080);     // fraction near one half on both axes
        sample_at(20'sh00100, 20'sh00040);     // large u weight, small v weight
        sample_at(20'sh80000, 20'shfffff);     // negative, clamps to zero
        sample_at(20'sh10000, 20'sh10000);     // exactly one, last row and column
        sample_at(20'sh7ffff, 20'sh10001);     // above one, clamps
        sample_at(20'sh80000, 20'sh7ffff);     // first column, last row
        sample_at(20'sh00101, '0);             // first column, weight of the second column near one

        // each phase counts every word sent, corner fills included
        for (int p = 0; p < NUM_PHASES; p++) begin
            program_size(phase_w[p], phase_h[p]);
            if (p == HOLD_PHASE) begin
                bursts_on = 1'b0;
                hold_req  = 1'b1;
            end
            if (p == NUM_PHASES - 1) bursts_on = 1'b0;   // run out at full rate
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                if (p == HOLD_PHASE && words_sent - phase_start >= 40) bursts_on = 1'b1;
                random_word();
            end
        end

        tex.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d words and %0d filtered colours over %0d size settings",
                 words_sent, sb.checked, size_settings);
        $display("sizes from one texel to 256 by 256, zero and oversize codes, clamped coords");
        if (sb.mismatches == 0) begin
            $display("bilinear_texture_sampler test passed");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("bilinear_texture_sampler test failed");
        end
        $finish;
    end

endmodule
